// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the line stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BLSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BLSP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/blsp_pkg.sv =====
// Shared types, constants and width helpers for the Bresenham line stepper.
package blsp_pkg;

  // Fixed field widths
  localparam int unsigned DIM_W       = 11;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Action codes carried on the input tuser
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Configuration reset values
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  // Control flags of one queued command
  typedef struct packed {
    logic is_start;  // start a new line, else advance one pixel
    logic x_neg;     // x steps downward
    logic y_neg;     // y steps downward
    logic x_major;   // x is the major axis
    logic nonzero;   // endpoints differ, line has pixels
  } cmd_ctl_t;

  // Signed error term width for a given coordinate width
  function automatic int unsigned err_w(input int unsigned cb);
    return cb + 4;
  endfunction

  // Width of the doubled deltas
  function automatic int unsigned inc_w(input int unsigned cb);
    return cb + 2;
  endfunction

  // Packed command payload: four coordinates, color, error, two increments
  function automatic int unsigned cmd_data_w(input int unsigned cb);
    return 4 * cb + COLOR_W + err_w(cb) + 2 * inc_w(cb);
  endfunction

endpackage

// ===== hw/rtl/blsp_front.sv =====
// Front end: accepts input items, classifies them and computes line setup.
module blsp_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                         s_valid_i,
  output logic                                         s_ready_o,
  input  logic                                         action_i,
  input  logic signed [COORD_BITS-1:0]                 x_start_i,
  input  logic signed [COORD_BITS-1:0]                 y_start_i,
  input  logic signed [COORD_BITS-1:0]                 x_end_i,
  input  logic signed [COORD_BITS-1:0]                 y_end_i,
  input  logic [blsp_pkg::COLOR_W-1:0]                 line_color_i,
  input  logic                                         q_full_i,
  output logic                                         push_o,
  output blsp_pkg::cmd_ctl_t                           push_ctl_o,
  output logic [blsp_pkg::cmd_data_w(COORD_BITS)-1:0]  push_data_o
);
  import blsp_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned E_W = err_w(COORD_BITS);
  localparam int unsigned D_W = inc_w(COORD_BITS);

  logic signed [C:0]     dx_s, dy_s;
  logic [C:0]            mag_x, mag_y;
  logic [C:0]            major, minor;
  logic                  x_major;
  logic signed [E_W-1:0] err_init;
  logic [D_W-1:0]        diag_inc, step_inc;

  // Signed deltas and their magnitudes
  assign dx_s  = {x_end_i[C-1], x_end_i} - {x_start_i[C-1], x_start_i};
  assign dy_s  = {y_end_i[C-1], y_end_i} - {y_start_i[C-1], y_start_i};
  assign mag_x = dx_s[C] ? (~dx_s + 1'b1) : dx_s;
  assign mag_y = dy_s[C] ? (~dy_s + 1'b1) : dy_s;

  // Major axis choice; ties go to y
  assign x_major = mag_x > mag_y;
  assign major   = x_major ? mag_x : mag_y;
  assign minor   = x_major ? mag_y : mag_x;

  // Initial error 2*minor - major, and the two doubled increments
  assign err_init = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
  assign diag_inc = {major, 1'b0};
  assign step_inc = {minor, 1'b0};

  // Classification flags
  always_comb begin
    push_ctl_o.is_start = (action_i == ACT_START);
    push_ctl_o.x_neg    = dx_s[C];
    push_ctl_o.y_neg    = dy_s[C];
    push_ctl_o.x_major  = x_major;
    push_ctl_o.nonzero  = (x_start_i != x_end_i) || (y_start_i != y_end_i);
  end

  // Payload, lowest bits first: xs, ys, xe, ye, color, error, diag, step
  assign push_data_o = {step_inc, diag_inc, err_init, line_color_i,
                        y_end_i, x_end_i, y_start_i, x_start_i};

  // Handshake with the command queue
  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

endmodule

// ===== hw/rtl/blsp_queue.sv =====
// Short command queue between the front end and the stepping back end.
module blsp_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  blsp_pkg::cmd_ctl_t  push_ctl_i,
  input  logic [DATA_W-1:0]   push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output blsp_pkg::cmd_ctl_t  head_ctl_o,
  output logic [DATA_W-1:0]   head_data_o
);
  import blsp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_ctl_t          ctl_mem  [DEPTH];
  logic [DATA_W-1:0] data_mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ctl_mem[wr_ptr_q]  <= push_ctl_i;
      data_mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_ctl_o  = ctl_mem[rd_ptr_q];
  assign head_data_o = data_mem[rd_ptr_q];

endmodule

// ===== hw/rtl/blsp_back.sv =====
// Back end: holds the line state, takes one Bresenham step per advance.
module blsp_back #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         head_valid_i,
  input  blsp_pkg::cmd_ctl_t                           head_ctl_i,
  input  logic [blsp_pkg::cmd_data_w(COORD_BITS)-1:0]  head_data_i,
  output logic                                         pop_o,
  input  logic [blsp_pkg::DIM_W-1:0]                   image_width_i,
  input  logic [blsp_pkg::DIM_W-1:0]                   image_height_i,
  output logic                                         m_valid_o,
  input  logic                                         m_ready_i,
  output logic [COORD_BITS-1:0]                        pixel_x_o,
  output logic [COORD_BITS-1:0]                        pixel_y_o,
  output logic [blsp_pkg::COLOR_W-1:0]                 pixel_color_o,
  output logic                                         inside_o,
  output logic                                         last_o
);
  import blsp_pkg::*;

  localparam int unsigned C        = COORD_BITS;
  localparam int unsigned E_W      = err_w(COORD_BITS);
  localparam int unsigned D_W      = inc_w(COORD_BITS);
  localparam int unsigned CW       = (C > DIM_W) ? C : DIM_W;
  localparam int unsigned OFF_YS   = C;
  localparam int unsigned OFF_XE   = 2 * C;
  localparam int unsigned OFF_YE   = 3 * C;
  localparam int unsigned OFF_COL  = 4 * C;
  localparam int unsigned OFF_ERR  = OFF_COL + COLOR_W;
  localparam int unsigned OFF_DIAG = OFF_ERR + E_W;
  localparam int unsigned OFF_STEP = OFF_DIAG + D_W;

  // Line state
  logic [C-1:0]          cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [C-1:0]          stop_x_q, stop_y_q;
  logic signed [E_W-1:0] err_q, err_d;
  logic [D_W-1:0]        diag_q, step_q;
  logic                  x_neg_q, y_neg_q, x_major_q;
  logic                  active_q, active_d;
  logic [COLOR_W-1:0]    color_q;

  // Output register
  logic                  out_valid_q, out_valid_d;

  logic                  load, emit, out_free;
  logic                  diag_step, move_x, move_y, done, in_image;
  logic [C-1:0]          x_inc, y_inc;

  // Command dispatch: starts and idle advances never wait on the output
  assign out_free = !out_valid_q || m_ready_i;
  assign load     = head_valid_i && head_ctl_i.is_start;
  assign emit     = head_valid_i && !head_ctl_i.is_start && active_q && out_free;
  assign pop_o    = head_valid_i && (head_ctl_i.is_start || !active_q || out_free);

  // One step: diagonal when the error is positive, else along the major axis
  assign diag_step = !err_q[E_W-1] && (err_q != '0);
  assign move_x    = diag_step || x_major_q;
  assign move_y    = diag_step || !x_major_q;
  assign x_inc     = x_neg_q ? '1 : C'(1);
  assign y_inc     = y_neg_q ? '1 : C'(1);

  always_comb begin
    cur_x_d = move_x ? cur_x_q + x_inc : cur_x_q;
    cur_y_d = move_y ? cur_y_q + y_inc : cur_y_q;
    err_d   = err_q + $signed({2'b00, step_q});
    if (diag_step) begin
      err_d = err_d - $signed({2'b00, diag_q});
    end
  end

  assign done = (cur_x_d == stop_x_q) && (cur_y_d == stop_y_q);

  // Clipping against the image size
  assign in_image = !cur_x_q[C-1] && (CW'(cur_x_q) < CW'(image_width_i)) &&
                    !cur_y_q[C-1] && (CW'(cur_y_q) < CW'(image_height_i));

  // Control next state
  always_comb begin
    active_d = active_q;
    if (load) begin
      active_d = head_ctl_i.nonzero;
    end else if (emit && done) begin
      active_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Line state load and step
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_x_q   <= head_data_i[C-1:0];
      cur_y_q   <= head_data_i[OFF_YS +: C];
      stop_x_q  <= head_data_i[OFF_XE +: C];
      stop_y_q  <= head_data_i[OFF_YE +: C];
      color_q   <= head_data_i[OFF_COL +: COLOR_W];
      err_q     <= $signed(head_data_i[OFF_ERR +: E_W]);
      diag_q    <= head_data_i[OFF_DIAG +: D_W];
      step_q    <= head_data_i[OFF_STEP +: D_W];
      x_neg_q   <= head_ctl_i.x_neg;
      y_neg_q   <= head_ctl_i.y_neg;
      x_major_q <= head_ctl_i.x_major;
    end else if (emit) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      err_q   <= err_d;
    end
  end

  // Pixel output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_x_o     <= cur_x_q;
      pixel_y_o     <= cur_y_q;
      pixel_color_o <= color_q;
      inside_o      <= in_image;
      last_o        <= done;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/bresenham_line_stepper.sv =====
// Top level of the Bresenham line stepper: ports, configuration, wiring.
//
// Input stream (s_axis): tuser is the action, 0 starts a line, 1 advances
// one pixel. A start carries both signed endpoints and the color in tdata
// and gives no output; an advance on an active line gives one pixel.
// Output stream (m_axis): one transaction per pixel, tlast set on the pixel
// whose step reaches the end point (the end point itself is not emitted),
// tuser set when the pixel lies inside the configured image.
// Configuration channel: cfg_index_i 0 writes the image width, 1 the image
// height; always ready. The user must write it only while the stream is idle,
// which the block does not enforce. Throughput: one item per clock while
// m_axis is not stalled. Each advance takes one error update and one endpoint
// compare in the back end; a two-entry command queue sits between input decode
// and that stepper, and a pixel output register feeds m_axis.
// Reset: the line is idle, width 640, height 480, no pixel pending.
// Output stall: the pixel holds on m_axis, the queue fills, and s_axis_tready
// drops once both queue entries are taken.
module bresenham_line_stepper #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: x_start, y_start, x_end, y_end, line_color (lowest bit first)
  input  logic [((4*COORD_BITS+blsp_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // tuser: action
  input  logic                                                s_axis_tuser,
  input  logic                                                s_axis_tvalid,
  output logic                                                s_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_color (lowest bit first)
  output logic [((2*COORD_BITS+blsp_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  // tuser: inside_res
  output logic                                                m_axis_tuser,
  // tlast: last
  output logic                                                m_axis_tlast,
  output logic                                                m_axis_tvalid,
  input  logic                                                m_axis_tready,
  input  logic                                                cfg_valid_i,
  output logic                                                cfg_ready_o,
  input  logic [blsp_pkg::CFG_IDX_W-1:0]                      cfg_index_i,
  input  logic [blsp_pkg::DIM_W-1:0]                          cfg_data_i
);
  import blsp_pkg::*;

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned CMD_W  = cmd_data_w(COORD_BITS);
  localparam int unsigned OUT_W  = ((2 * C + COLOR_W + 7) / 8) * 8;

  logic [DIM_W-1:0]   image_width_q, image_height_q;
  logic               q_full, push, pop, head_valid;
  cmd_ctl_t           push_ctl, head_ctl;
  logic [CMD_W-1:0]   push_data, head_data;
  logic [C-1:0]       pixel_x, pixel_y;
  logic [COLOR_W-1:0] pixel_color;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input decode and setup
  blsp_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .action_i     (s_axis_tuser),
    .x_start_i    ($signed(s_axis_tdata[C-1:0])),
    .y_start_i    ($signed(s_axis_tdata[2*C-1:C])),
    .x_end_i      ($signed(s_axis_tdata[3*C-1:2*C])),
    .y_end_i      ($signed(s_axis_tdata[4*C-1:3*C])),
    .line_color_i (s_axis_tdata[4*C+COLOR_W-1:4*C]),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_ctl_o   (push_ctl),
    .push_data_o  (push_data)
  );

  // Command queue
  blsp_queue #(
    .DATA_W (CMD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ctl_i   (push_ctl),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_ctl_o   (head_ctl),
    .head_data_o  (head_data)
  );

  // Stepper and pixel output register
  blsp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_ctl_i     (head_ctl),
    .head_data_i    (head_data),
    .pop_o          (pop),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_color_o  (pixel_color),
    .inside_o       (m_axis_tuser),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

// ===== hw/rtl/blsp_checker.sv =====
// Port-level assertions for the line stepper, bound to the top level.
`include "assert_macros.svh"

module blsp_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input logic                                                clk_i,
  input logic                                                rst_ni,
  input logic [((2*COORD_BITS+blsp_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  input logic                                                m_axis_tuser,
  input logic                                                m_axis_tlast,
  input logic                                                m_axis_tvalid,
  input logic                                                m_axis_tready,
  input logic                                                cfg_valid_i,
  input logic                                                cfg_ready_o
);

  // No pixel is offered while reset is held
  `BLSP_ASSERT_ALWAYS(a_reset_no_pixel, clk_i, !rst_ni |-> !m_axis_tvalid, "pixel valid in reset")

  // A stalled pixel stays offered
  `BLSP_ASSERT(a_valid_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "pixel dropped under stall")

  // A stalled pixel keeps its payload
  `BLSP_ASSERT(a_payload_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "pixel changed under stall")

  // Configuration writes are never stalled
  `BLSP_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_o, "config write stalled")

endmodule

bind bresenham_line_stepper blsp_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
